>>> rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants for the triangle barycentric classification core.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // Default geometry and fixed-point parameters.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Number of coordinate fields in one input transfer (A, B, C, P).
    localparam int N_COORDS = 12;

    // Width of the tolerance registers.
    localparam int TOL_W = 17;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_INSIDE_TOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_TOL   = 1'b1;

    // Vertex and edge codes.
    localparam logic [1:0] VTX_A   = 2'd0;
    localparam logic [1:0] VTX_B   = 2'd1;
    localparam logic [1:0] VTX_C   = 2'd2;
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

endpackage

>>> rtl/bcc_dot.sv
// ----------------------------------------------------------------------------
// bcc_dot
// Edge vectors and the five dot products, three register stages.
// ----------------------------------------------------------------------------
module bcc_dot #(
    parameter int CB = bcc_pkg::COORD_BITS_DEF,
    parameter int SW = 2 * (CB + 1) + 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [bcc_pkg::N_COORDS-1:0][CB-1:0]  coord,
    output logic                                  out_valid,
    output logic signed [SW-1:0]                  d00,
    output logic signed [SW-1:0]                  d01,
    output logic signed [SW-1:0]                  d11,
    output logic signed [SW-1:0]                  d20,
    output logic signed [SW-1:0]                  d21
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    logic [2:0] valid_reg;

    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] w_reg [3];

    logic signed [PW-1:0] puu_reg [3];
    logic signed [PW-1:0] puv_reg [3];
    logic signed [PW-1:0] pvv_reg [3];
    logic signed [PW-1:0] pwu_reg [3];
    logic signed [PW-1:0] pwv_reg [3];

    logic signed [SW-1:0] d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Stage 1: differences relative to vertex A.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= DW'($signed(coord[3 + i])) - DW'($signed(coord[i]));
                v_reg[i] <= DW'($signed(coord[6 + i])) - DW'($signed(coord[i]));
                w_reg[i] <= DW'($signed(coord[9 + i])) - DW'($signed(coord[i]));
            end
        end
    end

    // Stage 2: per-axis products, operands widened to the full product width.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                puu_reg[i] <= PW'(u_reg[i]) * PW'(u_reg[i]);
                puv_reg[i] <= PW'(u_reg[i]) * PW'(v_reg[i]);
                pvv_reg[i] <= PW'(v_reg[i]) * PW'(v_reg[i]);
                pwu_reg[i] <= PW'(w_reg[i]) * PW'(u_reg[i]);
                pwv_reg[i] <= PW'(w_reg[i]) * PW'(v_reg[i]);
            end
        end
    end

    // Stage 3: sum over the three axes.
    always_ff @(posedge aclk) begin
        if (en) begin
            d00_reg <= SW'(puu_reg[0]) + SW'(puu_reg[1]) + SW'(puu_reg[2]);
            d01_reg <= SW'(puv_reg[0]) + SW'(puv_reg[1]) + SW'(puv_reg[2]);
            d11_reg <= SW'(pvv_reg[0]) + SW'(pvv_reg[1]) + SW'(pvv_reg[2]);
            d20_reg <= SW'(pwu_reg[0]) + SW'(pwu_reg[1]) + SW'(pwu_reg[2]);
            d21_reg <= SW'(pwv_reg[0]) + SW'(pwv_reg[1]) + SW'(pwv_reg[2]);
        end
    end

    assign out_valid = valid_reg[2];
    assign d00 = d00_reg;
    assign d01 = d01_reg;
    assign d11 = d11_reg;
    assign d20 = d20_reg;
    assign d21 = d21_reg;

endmodule

>>> rtl/bcc_det.sv
// ----------------------------------------------------------------------------
// bcc_det
// Gram determinant, weight numerators and divider set-up, three stages.
// ----------------------------------------------------------------------------
module bcc_det #(
    parameter int SW = 28,
    parameter int NW = 2 * SW + 1,
    parameter int RW = NW + 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [SW-1:0]  d00,
    input  logic signed [SW-1:0]  d01,
    input  logic signed [SW-1:0]  d11,
    input  logic signed [SW-1:0]  d20,
    input  logic signed [SW-1:0]  d21,
    output logic                  out_valid,
    output logic                  deg,
    output logic [1:0]            sat_lo,   // lane 0: weight C, lane 1: weight B
    output logic [1:0]            sat_hi,
    output logic [1:0][RW-1:0]    dividend,
    output logic [RW-1:0]         divisor
);

    localparam int MW = 2 * SW;
    localparam int EW = NW + 3;

    logic [2:0] valid_reg;

    logic signed [MW-1:0] m0011_reg, m0101_reg, m0021_reg, m0120_reg, m1120_reg, m0121_reg;
    logic signed [NW-1:0] den_reg, nc_reg, nb_reg;

    logic                 deg_reg;
    logic [1:0]           lo_reg, hi_reg;
    logic [1:0][RW-1:0]   x_reg;
    logic [RW-1:0]        d8_reg;

    logic signed [EW-1:0] den_e, d4_e;
    logic signed [EW-1:0] num_e [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Stage 4: the six products of the determinant and numerators.
    always_ff @(posedge aclk) begin
        if (en) begin
            m0011_reg <= MW'(d00) * MW'(d11);
            m0101_reg <= MW'(d01) * MW'(d01);
            m0021_reg <= MW'(d00) * MW'(d21);
            m0120_reg <= MW'(d01) * MW'(d20);
            m1120_reg <= MW'(d11) * MW'(d20);
            m0121_reg <= MW'(d01) * MW'(d21);
        end
    end

    // Stage 5: differences of products.
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= NW'(m0011_reg) - NW'(m0101_reg);
            nc_reg  <= NW'(m0021_reg) - NW'(m0120_reg);
            nb_reg  <= NW'(m1120_reg) - NW'(m0121_reg);
        end
    end

    // Stage 6: range check and offset so the divider sees a value below 8*den.
    always_comb begin
        den_e    = EW'(den_reg);
        d4_e     = den_e <<< 2;
        num_e[0] = EW'(nc_reg);
        num_e[1] = EW'(nb_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg <= den_reg[NW-1] || (den_reg == '0);
            d8_reg  <= RW'($unsigned(den_e <<< 3));
            for (int i = 0; i < 2; i++) begin
                lo_reg[i] <= num_e[i] < -d4_e;
                hi_reg[i] <= num_e[i] >= d4_e;
                x_reg[i]  <= RW'($unsigned(num_e[i] + d4_e));
            end
        end
    end

    assign out_valid = valid_reg[2];
    assign deg       = deg_reg;
    assign sat_lo    = lo_reg;
    assign sat_hi    = hi_reg;
    assign dividend  = x_reg;
    assign divisor   = d8_reg;

endmodule

>>> rtl/bcc_div.sv
// ----------------------------------------------------------------------------
// bcc_div
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module bcc_div #(
    parameter int RW = 61,
    parameter int QW = 19
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic                in_deg,
    input  logic [1:0]          in_lo,
    input  logic [1:0]          in_hi,
    input  logic [1:0][RW-1:0]  dividend,
    input  logic [RW-1:0]       divisor,
    output logic                out_valid,
    output logic                out_deg,
    output logic [1:0]          out_lo,
    output logic [1:0]          out_hi,
    output logic [1:0][QW-1:0]  quotient
);

    logic [QW-1:0]          valid_reg;
    logic                   deg_reg  [QW];
    logic [1:0]             lo_reg   [QW];
    logic [1:0]             hi_reg   [QW];
    logic [1:0][RW-1:0]     rem_reg  [QW];
    logic [1:0][QW-1:0]     quo_reg  [QW];
    logic [RW-1:0]          dvs_reg  [QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    // Each stage doubles the partial remainder and subtracts the divisor if it fits.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [1:0][RW-1:0] rem_in;
        logic [1:0][QW-1:0] quo_in;
        logic [RW-1:0]      dvs_in;
        logic [1:0][RW-1:0] rem_sh;

        if (k == 0) begin : g_first
            assign rem_in = dividend;
            assign quo_in = '0;
            assign dvs_in = divisor;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
        end

        always_comb begin
            for (int i = 0; i < 2; i++) begin
                rem_sh[i] = {rem_in[i][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvs_reg[k] <= dvs_in;
                deg_reg[k] <= (k == 0) ? in_deg : deg_reg[(k == 0) ? 0 : k - 1];
                lo_reg[k]  <= (k == 0) ? in_lo  : lo_reg[(k == 0) ? 0 : k - 1];
                hi_reg[k]  <= (k == 0) ? in_hi  : hi_reg[(k == 0) ? 0 : k - 1];
                for (int i = 0; i < 2; i++) begin
                    if (rem_sh[i] >= dvs_in) begin
                        rem_reg[k][i] <= rem_sh[i] - dvs_in;
                        quo_reg[k][i] <= {quo_in[i][QW-2:0], 1'b1};
                    end else begin
                        rem_reg[k][i] <= rem_sh[i];
                        quo_reg[k][i] <= {quo_in[i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_deg   = deg_reg[QW-1];
    assign out_lo    = lo_reg[QW-1];
    assign out_hi    = hi_reg[QW-1];
    assign quotient  = quo_reg[QW-1];

endmodule

>>> rtl/bcc_class.sv
// ----------------------------------------------------------------------------
// bcc_class
// Weight saturation, weight A, inside test and snapping; output register.
// ----------------------------------------------------------------------------
module bcc_class #(
    parameter int FB = bcc_pkg::FRAC_BITS_DEF,
    parameter int QW = FB + 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic                           in_deg,
    input  logic [1:0]                     in_lo,
    input  logic [1:0]                     in_hi,
    input  logic [1:0][QW-1:0]             quotient,
    input  logic [bcc_pkg::TOL_W-1:0]      inside_tol,
    input  logic [bcc_pkg::TOL_W-1:0]      snap_tol,
    output logic                           out_valid,
    output logic signed [QW-1:0]           weight_a,
    output logic signed [QW-1:0]           weight_b,
    output logic signed [QW-1:0]           weight_c,
    output logic                           degenerate,
    output logic                           inside_res,
    output logic                           on_vertex,
    output logic [1:0]                     vertex_id,
    output logic                           on_edge,
    output logic [1:0]                     edge_id
);

    localparam int AW = QW + 2;
    localparam int CW = ((QW > bcc_pkg::TOL_W) ? QW : bcc_pkg::TOL_W) + 3;
    localparam logic signed [QW-1:0] WMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] WMIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [AW-1:0] ONE_A = AW'(1) <<< FB;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FB;

    logic [1:0] valid_reg;

    logic signed [QW-1:0] wb_reg, wc_reg, wa_reg;
    logic                 deg_reg;

    logic signed [QW-1:0] wl [2];
    logic signed [AW-1:0] wa_full;

    logic signed [QW-1:0] wa_o_reg, wb_o_reg, wc_o_reg;
    logic                 deg_o_reg, in_o_reg, onv_o_reg, one_o_reg;
    logic [1:0]           vid_o_reg, eid_o_reg;

    logic signed [CW-1:0] wt_e [3];
    logic signed [CW-1:0] itol_e, stol_e;
    logic [2:0]           ex;
    logic                 inside_next, onv_next, one_next;
    logic [1:0]           vid_next, eid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    // Saturate the divided weights; the offset of four ones is removed by
    // flipping the top quotient bit.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (in_lo[i]) begin
                wl[i] = WMIN;
            end else if (in_hi[i]) begin
                wl[i] = WMAX;
            end else begin
                wl[i] = $signed({~quotient[i][QW-1], quotient[i][QW-2:0]});
            end
        end
        wa_full = ONE_A - AW'(wl[1]) - AW'(wl[0]);
    end

    // Stage A: register weights, with weight A clamped.
    always_ff @(posedge aclk) begin
        if (en) begin
            wc_reg  <= wl[0];
            wb_reg  <= wl[1];
            deg_reg <= in_deg;
            if (wa_full > AW'(WMAX)) begin
                wa_reg <= WMAX;
            end else if (wa_full < AW'(WMIN)) begin
                wa_reg <= WMIN;
            end else begin
                wa_reg <= QW'(wa_full);
            end
        end
    end

    // Inside test and snap classification.
    always_comb begin
        wt_e[0] = CW'(wa_reg);
        wt_e[1] = CW'(wb_reg);
        wt_e[2] = CW'(wc_reg);
        itol_e  = $signed(CW'(inside_tol));
        stol_e  = $signed(CW'(snap_tol));
        inside_next = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if ((wt_e[i] < -itol_e) || (wt_e[i] > ONE_C + itol_e)) begin
                inside_next = 1'b0;
            end
            ex[i] = wt_e[i] > stol_e;
        end
        onv_next = 1'b0;
        one_next = 1'b0;
        vid_next = bcc_pkg::VTX_A;
        eid_next = bcc_pkg::EDGE_AB;
        case (ex)
            3'b001: begin
                onv_next = 1'b1;
                vid_next = bcc_pkg::VTX_A;
            end
            3'b010: begin
                onv_next = 1'b1;
                vid_next = bcc_pkg::VTX_B;
            end
            3'b100: begin
                onv_next = 1'b1;
                vid_next = bcc_pkg::VTX_C;
            end
            3'b011: begin
                one_next = 1'b1;
                eid_next = bcc_pkg::EDGE_AB;
            end
            3'b110: begin
                one_next = 1'b1;
                eid_next = bcc_pkg::EDGE_BC;
            end
            3'b101: begin
                one_next = 1'b1;
                eid_next = bcc_pkg::EDGE_CA;
            end
            default: begin
                onv_next = 1'b0;
            end
        endcase
    end

    // Stage B: output register; a degenerate triangle clears every field but the degenerate flag.
    always_ff @(posedge aclk) begin
        if (en) begin
            deg_o_reg <= deg_reg;
            if (deg_reg) begin
                wa_o_reg  <= '0;
                wb_o_reg  <= '0;
                wc_o_reg  <= '0;
                in_o_reg  <= 1'b0;
                onv_o_reg <= 1'b0;
                one_o_reg <= 1'b0;
                vid_o_reg <= bcc_pkg::VTX_A;
                eid_o_reg <= bcc_pkg::EDGE_AB;
            end else begin
                wa_o_reg  <= wa_reg;
                wb_o_reg  <= wb_reg;
                wc_o_reg  <= wc_reg;
                in_o_reg  <= inside_next;
                onv_o_reg <= onv_next;
                one_o_reg <= one_next;
                vid_o_reg <= vid_next;
                eid_o_reg <= eid_next;
            end
        end
    end

    assign out_valid  = valid_reg[1];
    assign weight_a   = wa_o_reg;
    assign weight_b   = wb_o_reg;
    assign weight_c   = wc_o_reg;
    assign degenerate = deg_o_reg;
    assign inside_res = in_o_reg;
    assign on_vertex  = onv_o_reg;
    assign vertex_id  = vid_o_reg;
    assign on_edge    = one_o_reg;
    assign edge_id    = eid_o_reg;

endmodule

>>> rtl/triangle_barycentric_classify_core.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_classify_core
// Classifies a query point against a 3D triangle by barycentric weights.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_ channel carries vertices A, B, C and a point P.
// Each transfer on the m_ channel carries the three signed fixed-point
// weights, the degenerate flag, the inside flag and the snap results.
// Exactly one result leaves for every input, in order.
// Results pass through three stages of dot products, three of determinant
// and numerators, one per quotient bit in the pipelined divider, then two
// of classification and output.
// Throughput is one transfer per cycle while m_tready is high.
// The pipeline advances as a whole; when the receiver stalls with a result
// waiting, every stage holds and s_tready is low, so nothing is lost.
// Reset clears all valid bits and sets both tolerances to zero.
// Tolerances are written on the cfg_ channel (index 0: inside tolerance,
// index 1: snap tolerance), which is always ready; write them while idle.
// ----------------------------------------------------------------------------
module triangle_barycentric_classify_core #(
    parameter int COORD_BITS = bcc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bcc_pkg::FRAC_BITS_DEF,
    parameter int IN_W  = ((bcc_pkg::N_COORDS * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((3 * (FRAC_BITS + 3) + 8 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz
    input  logic [IN_W-1:0]                   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // weight_a, weight_b, weight_c, degenerate, inside_res, on_vertex,
    // vertex_id, on_edge, edge_id
    output logic [OUT_W-1:0]                  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcc_pkg::TOL_W-1:0]         cfg_data
);

    localparam int QW = FRAC_BITS + 3;
    localparam int SW = 2 * (COORD_BITS + 1) + 2;
    localparam int NW = 2 * SW + 1;
    localparam int RW = NW + 4;
    localparam int FW = 3 * QW + 8;

    logic adv;

    logic [bcc_pkg::TOL_W-1:0] inside_tol_reg, snap_tol_reg;

    logic [bcc_pkg::N_COORDS-1:0][COORD_BITS-1:0] coord;

    logic                 dot_valid;
    logic signed [SW-1:0] d00, d01, d11, d20, d21;

    logic                 det_valid, det_deg;
    logic [1:0]           det_lo, det_hi;
    logic [1:0][RW-1:0]   det_x;
    logic [RW-1:0]        det_d8;

    logic                 div_valid, div_deg;
    logic [1:0]           div_lo, div_hi;
    logic [1:0][QW-1:0]   div_q;

    logic signed [QW-1:0] weight_a, weight_b, weight_c;
    logic                 degenerate, inside_res, on_vertex, on_edge;
    logic [1:0]           vertex_id, edge_id;

    // The whole pipeline moves unless a result waits at the output.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_tol_reg <= '0;
            snap_tol_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bcc_pkg::REG_INSIDE_TOL: inside_tol_reg <= cfg_data;
                bcc_pkg::REG_SNAP_TOL:   snap_tol_reg   <= cfg_data;
                default:                 inside_tol_reg <= inside_tol_reg;
            endcase
        end
    end

    // Unpack the coordinate fields.
    always_comb begin
        for (int i = 0; i < bcc_pkg::N_COORDS; i++) begin
            coord[i] = s_tdata[i * COORD_BITS +: COORD_BITS];
        end
    end

    bcc_dot #(
        .CB (COORD_BITS),
        .SW (SW)
    ) u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .coord     (coord),
        .out_valid (dot_valid),
        .d00       (d00),
        .d01       (d01),
        .d11       (d11),
        .d20       (d20),
        .d21       (d21)
    );

    bcc_det #(
        .SW (SW),
        .NW (NW),
        .RW (RW)
    ) u_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (dot_valid),
        .d00       (d00),
        .d01       (d01),
        .d11       (d11),
        .d20       (d20),
        .d21       (d21),
        .out_valid (det_valid),
        .deg       (det_deg),
        .sat_lo    (det_lo),
        .sat_hi    (det_hi),
        .dividend  (det_x),
        .divisor   (det_d8)
    );

    bcc_div #(
        .RW (RW),
        .QW (QW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (det_valid),
        .in_deg    (det_deg),
        .in_lo     (det_lo),
        .in_hi     (det_hi),
        .dividend  (det_x),
        .divisor   (det_d8),
        .out_valid (div_valid),
        .out_deg   (div_deg),
        .out_lo    (div_lo),
        .out_hi    (div_hi),
        .quotient  (div_q)
    );

    bcc_class #(
        .FB (FRAC_BITS),
        .QW (QW)
    ) u_class (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (div_valid),
        .in_deg     (div_deg),
        .in_lo      (div_lo),
        .in_hi      (div_hi),
        .quotient   (div_q),
        .inside_tol (inside_tol_reg),
        .snap_tol   (snap_tol_reg),
        .out_valid  (m_tvalid),
        .weight_a   (weight_a),
        .weight_b   (weight_b),
        .weight_c   (weight_c),
        .degenerate (degenerate),
        .inside_res (inside_res),
        .on_vertex  (on_vertex),
        .vertex_id  (vertex_id),
        .on_edge    (on_edge),
        .edge_id    (edge_id)
    );

    // Pack the result fields, lowest first, padded with zeros to whole bytes.
    assign m_tdata = {{(OUT_W - FW){1'b0}}, edge_id, on_edge, vertex_id, on_vertex,
                      inside_res, degenerate, weight_c, weight_b, weight_a};

`ifndef NO_ASSERTIONS
    // A degenerate result carries no classification.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && degenerate |-> !inside_res && !on_vertex && !on_edge)
        else $error("degenerate result with classification flags");

    // A point never snaps to a vertex and an edge at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(on_vertex && on_edge))
        else $error("vertex and edge snap both set");

    // Both identifiers are zero when neither flag is set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !on_vertex && !on_edge |->
            vertex_id == bcc_pkg::VTX_A && edge_id == bcc_pkg::EDGE_AB)
        else $error("snap identifier set without its flag");

    // A stalled output freezes the pipeline input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");
`endif

endmodule
